/* design/spi_pkg.sv */
// ---------------------------------------------------------------------------
// spi_pkg: shared types for the segment / plane intersection block
// Payload structs, the status codes and the queue entry format.
// ---------------------------------------------------------------------------
package spi_pkg;

    localparam int IDX_BITS    = 10;
    localparam int IDX_DEPTH   = 2 ** IDX_BITS;
    localparam int CRD_BITS    = 16;
    localparam int HIT_BITS    = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_CROSS    = 3'd1,
        ST_COPLANAR = 3'd2,
        ST_TOUCH_Q  = 3'd3,
        ST_TOUCH_R  = 3'd4
    } t_status;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic                        req_type;
        logic [IDX_BITS-1:0]         index_a;
        logic [IDX_BITS-1:0]         index_b;
        logic [IDX_BITS-1:0]         index_c;
        logic signed [CRD_BITS-1:0]  point_x;
        logic signed [CRD_BITS-1:0]  point_y;
        logic signed [CRD_BITS-1:0]  point_z;
        logic signed [CRD_BITS-1:0]  end_x;
        logic signed [CRD_BITS-1:0]  end_y;
        logic signed [CRD_BITS-1:0]  end_z;
    } t_req;

    typedef struct packed {
        logic [2:0]                  status;
        logic                        point_valid;
        logic signed [HIT_BITS-1:0]  hit_x;
        logic signed [HIT_BITS-1:0]  hit_y;
        logic signed [HIT_BITS-1:0]  hit_z;
        logic [1:0]                  largest_axis;
    } t_rsp;

    // one classified item between front and back: vertices already fetched
    typedef struct packed {
        logic                        wr;
        logic [2:0][CRD_BITS-1:0]    a;
        logic [2:0][CRD_BITS-1:0]    b;
        logic [2:0][CRD_BITS-1:0]    c;
        logic [2:0][CRD_BITS-1:0]    q;
        logic [2:0][CRD_BITS-1:0]    r;
    } t_item;

endpackage

/* design/spi_req_if.sv */
// ---------------------------------------------------------------------------
// spi_req_if: request channel
// Valid/ready channel carrying one request transfer.
// ---------------------------------------------------------------------------
interface spi_req_if;
    logic          valid;
    logic          ready;
    spi_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/spi_rsp_if.sv */
// ---------------------------------------------------------------------------
// spi_rsp_if: response channel
// Valid/ready channel carrying one result transfer.
// ---------------------------------------------------------------------------
interface spi_rsp_if;
    logic          valid;
    logic          ready;
    spi_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/spi_front.sv */
// ---------------------------------------------------------------------------
// spi_front: request intake and vertex store
// Takes requests, writes vertices, fetches the three triangle vertices.
// ---------------------------------------------------------------------------
module spi_front #(
    parameter int VERTEX_COUNT = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    spi_req_if.sink            i_req,
    output logic               o_valid,
    output spi_pkg::t_item     o_item,
    input  logic               i_ready
);
    localparam int MD = (VERTEX_COUNT < spi_pkg::IDX_DEPTH) ? VERTEX_COUNT
                                                            : spi_pkg::IDX_DEPTH;
    localparam int AW = $clog2(MD);
    localparam int CW = (COORD_BITS < spi_pkg::CRD_BITS) ? COORD_BITS
                                                         : spi_pkg::CRD_BITS;
    localparam int VW = 3 * spi_pkg::CRD_BITS;

    logic [VW-1:0] r_mem_a [MD];
    logic [VW-1:0] r_mem_b [MD];
    logic [VW-1:0] r_mem_c [MD];
    logic [VW-1:0] r_rd_a, r_rd_b, r_rd_c;
    logic          r_v;
    logic          r_wr;
    logic [2:0]    r_oor;
    logic [2:0][spi_pkg::CRD_BITS-1:0] r_q, r_r, w_q, w_r;
    logic          w_acc;
    logic          w_in_a, w_in_b, w_in_c;

    assign i_req.ready = !r_v || i_ready;
    assign w_acc       = i_req.valid && i_req.ready;

    // coordinates keep only the low COORD_BITS bits (at most CRD_BITS), sign extended
    always_comb begin
        w_q[0] = spi_pkg::CRD_BITS'($signed(i_req.payload.point_x[CW-1:0]));
        w_q[1] = spi_pkg::CRD_BITS'($signed(i_req.payload.point_y[CW-1:0]));
        w_q[2] = spi_pkg::CRD_BITS'($signed(i_req.payload.point_z[CW-1:0]));
        w_r[0] = spi_pkg::CRD_BITS'($signed(i_req.payload.end_x[CW-1:0]));
        w_r[1] = spi_pkg::CRD_BITS'($signed(i_req.payload.end_y[CW-1:0]));
        w_r[2] = spi_pkg::CRD_BITS'($signed(i_req.payload.end_z[CW-1:0]));
    end

    assign w_in_a = 32'(i_req.payload.index_a) < VERTEX_COUNT;
    assign w_in_b = 32'(i_req.payload.index_b) < VERTEX_COUNT;
    assign w_in_c = 32'(i_req.payload.index_c) < VERTEX_COUNT;

    // three copies of the store give three read ports
    always_ff @(posedge i_clk) begin
        if (w_acc && i_req.payload.req_type == spi_pkg::REQ_WRITE && w_in_a) begin
            r_mem_a[i_req.payload.index_a[AW-1:0]] <= w_q;
            r_mem_b[i_req.payload.index_a[AW-1:0]] <= w_q;
            r_mem_c[i_req.payload.index_a[AW-1:0]] <= w_q;
        end
        if (w_acc) begin
            r_rd_a <= r_mem_a[i_req.payload.index_a[AW-1:0]];
            r_rd_b <= r_mem_b[i_req.payload.index_b[AW-1:0]];
            r_rd_c <= r_mem_c[i_req.payload.index_c[AW-1:0]];
            r_wr   <= i_req.payload.req_type == spi_pkg::REQ_WRITE;
            r_oor  <= {!w_in_c, !w_in_b, !w_in_a};
            r_q    <= w_q;
            r_r    <= w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_acc) begin
            r_v <= 1'b1;
        end else if (i_ready) begin
            r_v <= 1'b0;
        end
    end

    // slots beyond the store read as the origin
    always_comb begin
        o_valid     = r_v;
        o_item.wr   = r_wr;
        o_item.a    = r_oor[0] ? '0 : r_rd_a;
        o_item.b    = r_oor[1] ? '0 : r_rd_b;
        o_item.c    = r_oor[2] ? '0 : r_rd_c;
        o_item.q    = r_q;
        o_item.r    = r_r;
    end
endmodule

/* design/spi_queue.sv */
// ---------------------------------------------------------------------------
// spi_queue: front to back decoupling queue
// Small FIFO of fetched items.
// ---------------------------------------------------------------------------
module spi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  spi_pkg::t_item  i_item,
    output logic            o_ready,
    output logic            o_valid,
    output spi_pkg::t_item  o_item,
    input  logic            i_pop
);
    localparam int PW = $clog2(spi_pkg::QUEUE_DEPTH);

    spi_pkg::t_item r_buf [spi_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    logic           w_push, w_pop;

    assign o_ready = r_cnt != (PW+1)'(spi_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_buf[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

/* design/spi_back.sv */
// ---------------------------------------------------------------------------
// spi_back: intersection pipeline
// Normal, plane terms, classification and a 32-stage restoring divider.
// ---------------------------------------------------------------------------
module spi_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  spi_pkg::t_item  i_item,
    output logic            o_pop,
    spi_rsp_if.source       o_rsp
);
    localparam int DW  = 72 + FRAC_BITS;   // shifted dividend magnitude
    localparam int QB  = spi_pkg::HIT_BITS;
    localparam int NST = 9 + QB + 1;
    localparam int SD  = 9;                // first divider stage

    typedef struct packed {
        logic              wr;
        logic [1:0]        axis;
        spi_pkg::t_status  status;
        logic              pv;
        logic              dneg;
        logic [53:0]       dmag;
        logic [2:0]        neg;
        logic [2:0]        ovf;
    } t_ctl;

    logic [NST-1:0] r_v;
    logic           w_en;
    t_ctl           r_ctl [NST];
    t_ctl           n_ctl [NST];

    logic signed [15:0] r1_a [3], r1_q [3];
    logic signed [16:0] r1_ab [3], r1_ac [3], r1_rq [3];
    logic signed [33:0] r2_p [6];
    logic signed [15:0] r2_a [3], r2_q [3];
    logic signed [16:0] r2_rq [3];
    logic signed [34:0] r3_n [3];
    logic signed [15:0] r3_a [3], r3_q [3];
    logic signed [16:0] r3_rq [3];
    logic signed [50:0] r4_an [3], r4_qn [3];
    logic signed [51:0] r4_rn [3];
    logic signed [15:0] r4_q [3];
    logic signed [16:0] r4_rq [3];
    logic signed [53:0] r5_num, r5_den;
    logic signed [15:0] r5_q [3];
    logic signed [16:0] r5_rq [3];
    logic signed [42:0] r6_bh [3];
    logic signed [43:0] r6_bl [3], r6_nh [3];
    logic signed [44:0] r6_nl [3];
    logic signed [71:0] r7_n [3];
    logic [DW-1:0]      r8_mag [3];
    logic [53:0]        r_rem [QB+1][3];
    logic [QB-1:0]      r_lo  [QB+1][3];
    logic [QB-1:0]      r_quo [QB+1][3];
    logic [53:0]        n_rem [QB+1][3];
    logic [QB-1:0]      n_lo  [QB+1][3];
    logic [QB-1:0]      n_quo [QB+1][3];
    logic [34:0]        w_m [3];
    logic [71:0]        w_mag72 [3];
    logic [54:0]        w_t [QB+1][3];
    logic [QB-1:0]      w_hit [3];
    spi_pkg::t_rsp      r_rsp, n_rsp;

    assign w_en  = !r_v[NST-1] || o_rsp.ready;
    assign o_pop = w_en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    // control word travels along with the data, updated where it is known
    always_comb begin
        n_ctl[0]      = '0;
        n_ctl[0].wr   = i_item.wr;
        for (int s = 1; s < NST; s++) begin
            n_ctl[s] = r_ctl[s-1];
        end
        for (int i = 0; i < 3; i++) begin
            w_m[i] = r3_n[i][34] ? 35'(-r3_n[i]) : 35'(r3_n[i]);
        end
        // strict first maximum of |N|
        n_ctl[3].axis = 2'd0;
        if (w_m[1] > w_m[0]) begin
            n_ctl[3].axis = 2'd1;
            if (w_m[2] > w_m[1]) n_ctl[3].axis = 2'd2;
        end else if (w_m[2] > w_m[0]) begin
            n_ctl[3].axis = 2'd2;
        end
        // classification from num and denom
        n_ctl[5].pv   = r5_den != '0;
        n_ctl[5].dneg = r5_den[53];
        n_ctl[5].dmag = r5_den[53] ? 54'(-r5_den) : 54'(r5_den);
        if (r5_den == '0) begin
            n_ctl[5].status = (r5_num == '0) ? spi_pkg::ST_COPLANAR : spi_pkg::ST_NONE;
        end else if ((r5_den > 0 && r5_num > 0 && r5_num < r5_den) ||
                     (r5_den < 0 && r5_num < 0 && r5_num > r5_den)) begin
            n_ctl[5].status = spi_pkg::ST_CROSS;
        end else if (r5_num == '0) begin
            n_ctl[5].status = spi_pkg::ST_TOUCH_Q;
        end else if (r5_num == r5_den) begin
            n_ctl[5].status = spi_pkg::ST_TOUCH_R;
        end else begin
            n_ctl[5].status = spi_pkg::ST_NONE;
        end
        for (int i = 0; i < 3; i++) begin
            n_ctl[7].neg[i] = r7_n[i][71] ^ r_ctl[6].dneg;
            n_ctl[8].ovf[i] = 64'(r8_mag[i][DW-1:QB]) >= 64'(r_ctl[7].dmag);
            w_mag72[i]      = r7_n[i][71] ? 72'(-r7_n[i]) : 72'(r7_n[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NST; s++) begin
                r_ctl[s] <= n_ctl[s];
            end
        end
    end

    // arithmetic stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                // S1: edges and direction
                r1_a[i]  <= $signed(i_item.a[i]);
                r1_q[i]  <= $signed(i_item.q[i]);
                r1_ab[i] <= 17'($signed(i_item.b[i])) - 17'($signed(i_item.a[i]));
                r1_ac[i] <= 17'($signed(i_item.c[i])) - 17'($signed(i_item.a[i]));
                r1_rq[i] <= 17'($signed(i_item.r[i])) - 17'($signed(i_item.q[i]));
                r2_a[i]  <= r1_a[i];
                r2_q[i]  <= r1_q[i];
                r2_rq[i] <= r1_rq[i];
                r3_a[i]  <= r2_a[i];
                r3_q[i]  <= r2_q[i];
                r3_rq[i] <= r2_rq[i];
                // S4: dot product terms
                r4_an[i] <= r3_a[i] * r3_n[i];
                r4_qn[i] <= r3_q[i] * r3_n[i];
                r4_rn[i] <= r3_rq[i] * r3_n[i];
                r4_q[i]  <= r3_q[i];
                r4_rq[i] <= r3_rq[i];
                r5_q[i]  <= r4_q[i];
                r5_rq[i] <= r4_rq[i];
                // S6: base*den and num*delta in 27-bit halves
                r6_bh[i] <= r5_q[i] * $signed(r5_den[53:27]);
                r6_bl[i] <= r5_q[i] * $signed({1'b0, r5_den[26:0]});
                r6_nh[i] <= $signed(r5_num[53:27]) * r5_rq[i];
                r6_nl[i] <= $signed({1'b0, r5_num[26:0]}) * r5_rq[i];
                // S7: signed dividend
                r7_n[i]  <= (72'(r6_bh[i]) <<< 27) + 72'(r6_bl[i])
                          + (72'(r6_nh[i]) <<< 27) + 72'(r6_nl[i]);
                // S8: magnitude, fraction shift
                r8_mag[i] <= DW'(w_mag72[i]) << FRAC_BITS;
            end
            // S2: cross product terms
            r2_p[0] <= r1_ac[2] * r1_ab[1];
            r2_p[1] <= r1_ab[2] * r1_ac[1];
            r2_p[2] <= r1_ac[0] * r1_ab[2];
            r2_p[3] <= r1_ac[2] * r1_ab[0];
            r2_p[4] <= r1_ac[1] * r1_ab[0];
            r2_p[5] <= r1_ac[0] * r1_ab[1];
            // S3: normal
            r3_n[0] <= 35'(r2_p[0]) - 35'(r2_p[1]);
            r3_n[1] <= 35'(r2_p[2]) - 35'(r2_p[3]);
            r3_n[2] <= 35'(r2_p[4]) - 35'(r2_p[5]);
            // S5: num and denom
            r5_num <= 54'(r4_an[0]) + 54'(r4_an[1]) + 54'(r4_an[2])
                    - 54'(r4_qn[0]) - 54'(r4_qn[1]) - 54'(r4_qn[2]);
            r5_den <= 54'(r4_rn[0]) + 54'(r4_rn[1]) + 54'(r4_rn[2]);
        end
    end

    // divider: stage 0 loads, stages 1..QB each retire one quotient bit
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rem[0][i] = 54'(r8_mag[i][DW-1:QB]);
            n_lo[0][i]  = r8_mag[i][QB-1:0];
            n_quo[0][i] = '0;
            w_t[0][i]   = '0;
        end
        for (int k = 1; k <= QB; k++) begin
            for (int i = 0; i < 3; i++) begin
                w_t[k][i] = {r_rem[k-1][i], r_lo[k-1][i][QB-1]};
                n_lo[k][i] = r_lo[k-1][i] << 1;
                if (w_t[k][i] >= {1'b0, r_ctl[SD+k-2].dmag}) begin
                    n_rem[k][i] = 54'(w_t[k][i] - {1'b0, r_ctl[SD+k-2].dmag});
                    n_quo[k][i] = {r_quo[k-1][i][QB-2:0], 1'b1};
                end else begin
                    n_rem[k][i] = w_t[k][i][53:0];
                    n_quo[k][i] = {r_quo[k-1][i][QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= QB; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[k][i] <= n_rem[k][i];
                    r_lo[k][i]  <= n_lo[k][i];
                    r_quo[k][i] <= n_quo[k][i];
                end
            end
        end
    end

    // saturate, sign and mask
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_ctl[NST-2].neg[i]) begin
                w_hit[i] = (r_ctl[NST-2].ovf[i] || r_quo[QB][i] > {1'b1, {(QB-1){1'b0}}})
                         ? {1'b1, {(QB-1){1'b0}}} : -r_quo[QB][i];
            end else begin
                w_hit[i] = (r_ctl[NST-2].ovf[i] || r_quo[QB][i][QB-1])
                         ? {1'b0, {(QB-1){1'b1}}} : r_quo[QB][i];
            end
            if (!r_ctl[NST-2].pv || r_ctl[NST-2].wr) begin
                w_hit[i] = '0;
            end
        end
        n_rsp.hit_x        = w_hit[0];
        n_rsp.hit_y        = w_hit[1];
        n_rsp.hit_z        = w_hit[2];
        n_rsp.point_valid  = r_ctl[NST-2].pv && !r_ctl[NST-2].wr;
        n_rsp.status       = r_ctl[NST-2].wr ? spi_pkg::ST_NONE : r_ctl[NST-2].status;
        n_rsp.largest_axis = r_ctl[NST-2].wr ? 2'd0 : r_ctl[NST-2].axis;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_v[NST-1];
    assign o_rsp.payload = r_rsp;
endmodule

/* design/segment_plane_intersect_top.sv */
// Path: a registered front stage, the queue, then the back pipeline registers.
// Throughput: one transfer per cycle, writes and queries alike, while results
// are taken (three single-read store copies, fully pipelined divider).
// Reset (i_rst_n low, synchronous) empties the front, queue and pipeline; the
// vertex store is not cleared and a slot reads as undefined until written.
// ---------------------------------------------------------------------------
// segment_plane_intersect_top: segment against triangle plane
// Vertex store plus exact integer segment / plane intersection in Q16.16.
// ---------------------------------------------------------------------------
module segment_plane_intersect_top #(
    parameter int VERTEX_COUNT = 1024,
    parameter int COORD_BITS   = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spi_req_if.sink   i_req,
    spi_rsp_if.source o_rsp
);
    // front -> queue
    logic           w_f_valid, w_f_ready;
    spi_pkg::t_item w_f_item;
    // queue -> back
    logic           w_q_valid, w_q_pop;
    spi_pkg::t_item w_q_item;

    // Front: takes a request transfer each cycle the stage is free or draining,
    // writes the vertex store and fetches vertices A, B, C in parallel.
    spi_front #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (w_f_valid),
        .o_item  (w_f_item),
        .i_ready (w_f_ready)
    );

    // Queue: lets the front keep taking transfers while the back is stalled.
    spi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_item  (w_f_item),
        .o_ready (w_f_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    // Back: normal, num/denom, classification, division and saturation.
    // The whole pipeline advances whenever its output register is free.
    spi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_q_pop),
        .o_rsp   (o_rsp)
    );
endmodule

/* design/spi_checker.sv */
// ---------------------------------------------------------------------------
// spi_checker: port level checks for the intersection block
// Result consistency and output hold, bound to the top level.
// ---------------------------------------------------------------------------
module spi_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic [2:0]       i_status,
    input logic             i_pv,
    input logic [31:0]      i_hx,
    input logic [31:0]      i_hy,
    input logic [31:0]      i_hz
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped before transfer");

    a_zero_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_pv |-> i_hx == '0 && i_hy == '0 && i_hz == '0)
        else $error("hit point without valid point");

    a_hit_needs_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == spi_pkg::ST_CROSS || i_status == spi_pkg::ST_TOUCH_Q ||
                    i_status == spi_pkg::ST_TOUCH_R) |-> i_pv)
        else $error("hit status without point");

    a_coplanar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == spi_pkg::ST_COPLANAR |-> !i_pv)
        else $error("coplanar with nonzero denominator");
endmodule

bind segment_plane_intersect_top spi_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_status (o_rsp.payload.status),
    .i_pv     (o_rsp.payload.point_valid),
    .i_hx     (o_rsp.payload.hit_x),
    .i_hy     (o_rsp.payload.hit_y),
    .i_hz     (o_rsp.payload.hit_z)
);

/* test/segment_plane_intersect_top_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// segment_plane_intersect_top_test: self-checking bench for the intersection block
// Fills the vertex store, sends directed and random queries under varied
// idling and backpressure, and checks every result against a local predictor.
// ---------------------------------------------------------------------------
module segment_plane_intersect_top_test;

    localparam int VCOUNT = 1024;
    localparam int FRAC = 16;
    localparam int QUIET_LIMIT = 20000;

    // expected-result store plus mismatch reporting
    class hit_scoreboard;
        spi_pkg::t_rsp pending[$];
        int errors;

        function void note_request(spi_pkg::t_rsp exp);
            pending.push_back(exp);
        endfunction

        function void check_result(spi_pkg::t_rsp got);
            spi_pkg::t_rsp exp;
            if (pending.size() == 0) begin
                $error("result with no expectation: %p", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status exp %0d got %0d", exp.status, got.status); errors++;
            end
            if (got.point_valid !== exp.point_valid) begin
                $error("point_valid exp %0d got %0d", exp.point_valid, got.point_valid);
                errors++;
            end
            if (got.hit_x !== exp.hit_x) begin
                $error("hit_x exp %0d got %0d", exp.hit_x, got.hit_x); errors++;
            end
            if (got.hit_y !== exp.hit_y) begin
                $error("hit_y exp %0d got %0d", exp.hit_y, got.hit_y); errors++;
            end
            if (got.hit_z !== exp.hit_z) begin
                $error("hit_z exp %0d got %0d", exp.hit_z, got.hit_z); errors++;
            end
            if (got.largest_axis !== exp.largest_axis) begin
                $error("largest_axis exp %0d got %0d", exp.largest_axis, got.largest_axis);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    spi_req_if req_ch();
    spi_rsp_if rsp_ch();

    segment_plane_intersect_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    hit_scoreboard sb = new();

    // predictor's copy of the vertex store
    logic signed [15:0] vtx [VCOUNT][3];
    bit written [VCOUNT];
    int written_list[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 1'b0;
    int quiet_cycles = 0;

    // one Q16.16 coordinate: (base*den + num*delta) * 2^FRAC / den, truncated and saturated
    function automatic logic signed [31:0] hit_coord(longint base, longint delta,
                                                     longint num, longint den);
        logic signed [127:0] n, q;
        n = (128'(signed'(base)) * den + 128'(signed'(num)) * delta) <<< FRAC;
        q = n / 128'(signed'(den));
        if (q > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (q < -128'sh80000000) return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic spi_pkg::t_rsp predict_intersection(spi_pkg::t_req rq);
        spi_pkg::t_rsp o;
        longint a[3], b[3], c[3], q[3], r[3], ab[3], ac[3], d[3], nv[3];
        longint best, m, num, den;
        o = '0;
        q[0] = rq.point_x; q[1] = rq.point_y; q[2] = rq.point_z;
        r[0] = rq.end_x;   r[1] = rq.end_y;   r[2] = rq.end_z;
        if (rq.req_type == spi_pkg::REQ_WRITE) begin
            vtx[rq.index_a][0] = rq.point_x;
            vtx[rq.index_a][1] = rq.point_y;
            vtx[rq.index_a][2] = rq.point_z;
            if (!written[rq.index_a]) written_list.push_back(rq.index_a);
            written[rq.index_a] = 1'b1;
            return o;
        end
        for (int i = 0; i < 3; i++) begin
            a[i] = vtx[rq.index_a][i]; b[i] = vtx[rq.index_b][i];
            c[i] = vtx[rq.index_c][i];
            ab[i] = b[i] - a[i]; ac[i] = c[i] - a[i]; d[i] = r[i] - q[i];
        end
        nv[0] = ac[2] * ab[1] - ab[2] * ac[1];
        nv[1] = ac[0] * ab[2] - ac[2] * ab[0];
        nv[2] = ac[1] * ab[0] - ac[0] * ab[1];
        best = 0;
        for (int i = 0; i < 3; i++) begin
            m = nv[i] < 0 ? -nv[i] : nv[i];
            if (m > best) begin
                best = m;
                o.largest_axis = 2'(i);
            end
        end
        num = (a[0] - q[0]) * nv[0] + (a[1] - q[1]) * nv[1] + (a[2] - q[2]) * nv[2];
        den = d[0] * nv[0] + d[1] * nv[1] + d[2] * nv[2];
        if (den == 0) begin
            o.status = (num == 0) ? spi_pkg::ST_COPLANAR : spi_pkg::ST_NONE;
            return o;
        end
        o.point_valid = 1'b1;
        o.hit_x = hit_coord(q[0], d[0], num, den);
        o.hit_y = hit_coord(q[1], d[1], num, den);
        o.hit_z = hit_coord(q[2], d[2], num, den);
        if ((den > 0 && num > 0 && num < den) || (den < 0 && num < 0 && num > den))
            o.status = spi_pkg::ST_CROSS;
        else if (num == 0)
            o.status = spi_pkg::ST_TOUCH_Q;
        else if (num == den)
            o.status = spi_pkg::ST_TOUCH_R;
        else
            o.status = spi_pkg::ST_NONE;
        return o;
    endfunction

    // receiver: random stall, or a long hold when the hold flag is up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.payload);
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (i_rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[segment_plane_intersect_top] ERROR");
            $finish;
        end
    end

    // valid stays up between back-to-back transfers; idle cycles drop it
    task automatic send_item(spi_pkg::t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= rq;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(predict_intersection(rq));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    function automatic logic signed [15:0] rand_crd();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(20)) - 16'sd10;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic spi_pkg::t_req make_write(int slot, logic signed [15:0] x,
                                                 logic signed [15:0] y,
                                                 logic signed [15:0] z);
        spi_pkg::t_req rq;
        rq = '0;
        rq.req_type = spi_pkg::REQ_WRITE;
        rq.index_a = 10'(slot);
        rq.index_b = 10'($urandom);
        rq.index_c = 10'($urandom);
        rq.point_x = x; rq.point_y = y; rq.point_z = z;
        rq.end_x = 16'($urandom); rq.end_y = 16'($urandom); rq.end_z = 16'($urandom);
        return rq;
    endfunction

    function automatic spi_pkg::t_req make_query(int ia, int ib, int ic,
                                        logic signed [15:0] qx, logic signed [15:0] qy,
                                        logic signed [15:0] qz, logic signed [15:0] rx,
                                        logic signed [15:0] ry, logic signed [15:0] rz);
        spi_pkg::t_req rq;
        rq.req_type = spi_pkg::REQ_QUERY;
        rq.index_a = 10'(ia); rq.index_b = 10'(ib); rq.index_c = 10'(ic);
        rq.point_x = qx; rq.point_y = qy; rq.point_z = qz;
        rq.end_x = rx; rq.end_y = ry; rq.end_z = rz;
        return rq;
    endfunction

    function automatic int pick_slot();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    // mostly small geometry so crossings and touches happen; some full range
    task automatic random_item(bit wide);
        logic signed [15:0] c[6];
        for (int i = 0; i < 6; i++)
            c[i] = wide ? rand_crd() : 16'($urandom_range(40)) - 16'sd20;
        if ($urandom_range(99) < 25 || written_list.size() < 3)
            send_item(make_write($urandom_range(VCOUNT - 1), c[0], c[1], c[2]));
        else if ($urandom_range(9) == 0)
            // segment starts at a stored vertex: reuse the first written vertex as q
            send_item(make_query(pick_slot(), pick_slot(), pick_slot(),
                vtx[written_list[0]][0], vtx[written_list[0]][1],
                vtx[written_list[0]][2], c[3], c[4], c[5]));
        else
            send_item(make_query(pick_slot(), pick_slot(), pick_slot(),
                                 c[0], c[1], c[2], c[3], c[4], c[5]));
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: triangle in z=0 plane, extremes, degenerate, slot extremes
        send_item(make_write(0, 0, 0, 0));
        send_item(make_write(1, 4, 0, 0));
        send_item(make_write(2, 0, 4, 0));
        send_item(make_write(1023, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
        send_item(make_write(3, 16'sh8000, 16'sh7FFF, 16'sh8000));
        send_item(make_write(4, 8, 0, 0));
        send_item(make_query(0, 1, 2, 1, 1, -2, 1, 1, 2));          // crossing
        send_item(make_query(0, 1, 2, 1, 1, 0, 3, 2, 5));           // touches q
        send_item(make_query(0, 1, 2, 1, 1, 5, 1, 1, 0));           // touches r
        send_item(make_query(0, 1, 2, 1, 1, 1, 5, 5, 1));           // parallel
        send_item(make_query(0, 1, 2, 1, 1, 0, 5, 5, 0));           // coplanar
        send_item(make_query(0, 1, 2, 1, 1, 2, 1, 1, 5));           // beyond segment
        send_item(make_query(0, 1, 4, 1, 2, 3, 4, 5, 6));           // degenerate
        send_item(make_query(0, 0, 0, 1, 2, 3, 4, 5, 6));           // all-zero normal
        send_item(make_query(1023, 3, 0, 16'sh8000, 16'sh8000, 16'sh8000,
                             16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_item(make_query(3, 1023, 2, 16'sh7FFF, 16'sh8000, 0,
                             16'sh7FFE, 16'sh8000, 1));            // saturating hit
        send_item(make_query(2, 0, 1, 0, 0, 16'sh7FFF, 0, 0, 16'sh7FFE));
        send_item(make_query(2, 1, 0, 1, 1, 16'sh8000, 1, 1, 16'sh8001));
        wait_drained();

        // pressure: long receiver hold while the sender keeps offering,
        // more items than the front, queue and pipeline can hold
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 80; i++) random_item(1'b0);
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        join
        wait_drained();

        // idle profiles: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 73 : 27) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 73 : 27) : 0;
            for (int i = 0; i < 190; i++) random_item($urandom_range(3) == 0);
            wait_drained();   // sender pauses until every result is back
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[segment_plane_intersect_top] OK");
        else
            $display("[segment_plane_intersect_top] ERROR");
        $finish;
    end
endmodule
